/* design/ile_pkg.sv */
// Shared constants, codes and types of the indexed list engine.
package ile_pkg;

	localparam int DEPTH      = 64;
	localparam int VALUE_BITS = 32;
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int POS_W      = 7;
	localparam int FUNC_W     = 3;
	localparam int STATUS_W   = 2;
	localparam int WHERE_W    = 6;
	localparam int GRP        = 8;
	localparam int NGRP       = DEPTH / GRP;
	localparam int GRP_W      = $clog2(GRP);
	localparam int NGRP_W     = $clog2(NGRP);

	typedef logic [VALUE_BITS-1:0] value_t;

	typedef enum logic [FUNC_W-1:0] {
		FN_INSERT  = 3'd0,
		FN_REMOVE  = 3'd1,
		FN_READ    = 3'd2,
		FN_REPLACE = 3'd3,
		FN_FIND    = 3'd4,
		FN_MATCH   = 3'd5,
		FN_CLEAR   = 3'd6
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_OPEN,
		CELL_CLOSE,
		CELL_WRITE
	} cell_op_t;

	typedef struct packed {
		cell_op_t          op;
		logic [IDX_W-1:0]  idx;
		value_t            data;
	} cell_cmd_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN1,
		S_SCAN2,
		S_FDONE,
		S_RESP
	} seq_state_t;

endpackage

/* design/ile_ifs.sv */
// Valid/ready channel interfaces for list requests and list responses.
interface ile_req_if
	import ile_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [FUNC_W-1:0]   func;
	logic [POS_W-1:0]    position;
	logic                from_end;
	value_t              item_value;

	modport source (output valid, func, position, from_end, item_value, input ready);
	modport sink   (input valid, func, position, from_end, item_value, output ready);
endinterface

interface ile_rsp_if
	import ile_pkg::*;
();
	logic                valid;
	logic                ready;
	value_t              value_out;
	logic [WHERE_W-1:0]  where_found;
	logic                found;
	logic [STATUS_W-1:0] status;
	logic [CNT_W-1:0]    count;

	modport source (output valid, value_out, where_found, found, status, count, input ready);
	modport sink   (input valid, value_out, where_found, found, status, count, output ready);
endinterface

/* design/indexed_list_engine_core.sv */
// Top level of the indexed list engine: cell chain, search tree and sequencer.
//
// Usage: a bounded ordered list of up to DEPTH values. Each request beat on
// req carries func, position, from_end and item_value; each one gives exactly
// one response beat on rsp with value_out, where_found, found, status and
// count (elements held after the operation). Positions count from the head,
// or from the tail when from_end is set.
// Sequence: insert, remove, read, replace and clear pass through the idle,
// execute and response states before the response is registered. Find and
// remove match also pass through the scan and find-done states: the hit vector
// of all cells runs through a two-level registered priority tree before the
// first match is known. Requests are taken one at a time; req.ready is high
// only while the sequencer is idle.
// Stall: a response waits in the output register while rsp.ready is low and
// the next request is taken meanwhile; a second response holds in the
// sequencer until the output register frees up.
// Reset: arst_n clears the count, the sequencer and the output valid at once.
// Cell contents are not cleared; only cells below the count are ever read.
module indexed_list_engine_core
	import ile_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	ile_req_if.sink  req,
	ile_rsp_if.source rsp
);

	seq_state_t state_q, state_d;

	// latched request
	logic [FUNC_W-1:0] func_q;
	logic [POS_W-1:0]  pos_q;
	logic              from_end_q;
	value_t            val_q;

	logic [CNT_W-1:0]  count_q, count_d;

	// pending response
	value_t              res_value_q, res_value_d;
	logic [WHERE_W-1:0]  res_where_q, res_where_d;
	logic                res_found_q, res_found_d;
	logic [STATUS_W-1:0] res_status_q, res_status_d;
	logic                res_we;

	// output register
	logic                out_valid_q;
	value_t              out_value_q;
	logic [WHERE_W-1:0]  out_where_q;
	logic                out_found_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [CNT_W-1:0]    out_count_q;
	logic                out_free;

	cell_cmd_t        cmd;
	value_t           cell_val [DEPTH];
	logic [DEPTH-1:0] cell_match;
	logic [DEPTH-1:0] hits;
	logic             search_load;
	logic             hit_any;
	logic [IDX_W-1:0] hit_idx;

	logic             ins_full, ins_bad, acc_bad;
	logic [CNT_W-1:0] ins_idx_full, acc_idx_full;
	logic [IDX_W-1:0] ins_idx, acc_idx;
	value_t           rd_val;

	// cell chain
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		value_t left_v, right_v;
		if (g == 0) begin : g_head
			assign left_v = cmd.data;
		end else begin : g_mid_l
			assign left_v = cell_val[g-1];
		end
		if (g == DEPTH - 1) begin : g_tail
			assign right_v = cell_val[g];
		end else begin : g_mid_r
			assign right_v = cell_val[g+1];
		end
		ile_cell u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.my_index  (IDX_W'(g)),
			.left_val  (left_v),
			.right_val (right_v),
			.value     (cell_val[g]),
			.match     (cell_match[g])
		);
		// drop hits from cells past the count
		assign hits[g] = cell_match[g] & (CNT_W'(g) < count_q);
	end

	ile_search u_search (
		.clk     (clk),
		.load    (search_load),
		.hits    (hits),
		.hit_any (hit_any),
		.hit_idx (hit_idx)
	);

	// position checks and head-based slot
	assign ins_full     = (count_q == CNT_W'(DEPTH));
	assign ins_bad      = (pos_q > count_q);
	assign acc_bad      = (pos_q >= count_q);
	assign ins_idx_full = from_end_q ? (count_q - pos_q) : pos_q;
	assign acc_idx_full = from_end_q ? (count_q - CNT_W'(1) - pos_q) : pos_q;
	assign ins_idx      = ins_idx_full[IDX_W-1:0];
	assign acc_idx      = acc_idx_full[IDX_W-1:0];

	// select the addressed cell
	always_comb begin
		rd_val = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (IDX_W'(i) == acc_idx) begin
				rd_val = rd_val | cell_val[i];
			end
		end
	end

	assign out_free  = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (req.valid) state_d = S_EXEC;
			S_EXEC: begin
				if (func_q == FN_FIND || func_q == FN_MATCH) begin
					state_d = S_SCAN1;
				end else begin
					state_d = S_RESP;
				end
			end
			S_SCAN1: state_d = S_SCAN2;
			S_SCAN2: state_d = S_FDONE;
			S_FDONE: state_d = S_RESP;
			S_RESP:  if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs: cell command, count update, pending response
	always_comb begin
		cmd.op       = CELL_HOLD;
		cmd.idx      = '0;
		cmd.data     = val_q;
		count_d      = count_q;
		search_load  = 1'b0;
		res_we       = 1'b0;
		res_value_d  = '0;
		res_where_d  = '0;
		res_found_d  = 1'b0;
		res_status_d = ST_OK;
		unique case (state_q)
			S_EXEC: begin
				res_we = 1'b1;
				case (func_q) inside
					FN_INSERT: begin
						if (ins_full) begin
							res_status_d = ST_FULL;
						end else if (ins_bad) begin
							res_status_d = ST_RANGE;
						end else begin
							cmd.op  = CELL_OPEN;
							cmd.idx = ins_idx;
							count_d = count_q + CNT_W'(1);
						end
					end
					FN_REMOVE, FN_READ, FN_REPLACE: begin
						if (acc_bad) begin
							res_status_d = ST_RANGE;
						end else begin
							res_value_d = rd_val;
							cmd.idx     = acc_idx;
							if (func_q == FN_REMOVE) begin
								cmd.op  = CELL_CLOSE;
								count_d = count_q - CNT_W'(1);
							end else if (func_q == FN_REPLACE) begin
								cmd.op = CELL_WRITE;
							end
						end
					end
					FN_FIND, FN_MATCH: begin
						// capture the hit vector; the response comes after the scan
						search_load = 1'b1;
						res_we      = 1'b0;
					end
					FN_CLEAR: count_d = '0;
					default: begin
					end
				endcase
			end
			S_FDONE: begin
				res_we = 1'b1;
				if (hit_any) begin
					res_found_d = 1'b1;
					res_where_d = WHERE_W'(hit_idx);
					res_value_d = val_q;
					if (func_q == FN_MATCH) begin
						cmd.op  = CELL_CLOSE;
						cmd.idx = hit_idx;
						count_d = count_q - CNT_W'(1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (state_q == S_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req.valid) begin
			func_q     <= req.func;
			pos_q      <= req.position;
			from_end_q <= req.from_end;
			val_q      <= req.item_value;
		end
		if (res_we) begin
			res_value_q  <= res_value_d;
			res_where_q  <= res_where_d;
			res_found_q  <= res_found_d;
			res_status_q <= res_status_d;
		end
		if (state_q == S_RESP && out_free) begin
			out_value_q  <= res_value_q;
			out_where_q  <= res_where_q;
			out_found_q  <= res_found_q;
			out_status_q <= res_status_q;
			out_count_q  <= count_q;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.value_out   = out_value_q;
	assign rsp.where_found = out_where_q;
	assign rsp.found       = out_found_q;
	assign rsp.status      = out_status_q;
	assign rsp.count       = out_count_q;

endmodule

/* design/ile_cell.sv */
// One list cell: holds one element, shifts with its neighbors, compares with the key.
module ile_cell
	import ile_pkg::*;
(
	input  logic             clk,
	input  cell_cmd_t        cmd,
	input  logic [IDX_W-1:0] my_index,
	input  value_t           left_val,
	input  value_t           right_val,
	output value_t           value,
	output logic             match
);

	value_t value_q;

	always_ff @(posedge clk) begin
		case (cmd.op)
			CELL_OPEN: begin
				// open a gap: cells past the slot take the left neighbor
				if (my_index > cmd.idx) begin
					value_q <= left_val;
				end else if (my_index == cmd.idx) begin
					value_q <= cmd.data;
				end
			end
			CELL_CLOSE: begin
				// close the gap: the slot and all after it take the right neighbor
				if (my_index >= cmd.idx) begin
					value_q <= right_val;
				end
			end
			CELL_WRITE: begin
				if (my_index == cmd.idx) begin
					value_q <= cmd.data;
				end
			end
			default: begin
			end
		endcase
	end

	assign value = value_q;
	assign match = (value_q == cmd.data);

endmodule

/* design/ile_search.sv */
// Registered two-level priority tree that finds the first hit among the cells.
module ile_search
	import ile_pkg::*;
(
	input  logic             clk,
	input  logic             load,
	input  logic [DEPTH-1:0] hits,
	output logic             hit_any,
	output logic [IDX_W-1:0] hit_idx
);

	logic [DEPTH-1:0] hits_s1;
	logic [NGRP-1:0]  grp_any_s2;
	logic [GRP_W-1:0] grp_idx_s2 [NGRP];
	logic             any_s3;
	logic [IDX_W-1:0] idx_s3;

	logic [NGRP-1:0]  grp_any_d;
	logic [GRP_W-1:0] grp_idx_d [NGRP];
	logic             any_d;
	logic [IDX_W-1:0] idx_d;

	always_ff @(posedge clk) begin
		if (load) begin
			hits_s1 <= hits;
		end
	end

	// first level: lowest hit inside each group
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_any_d[g] = |hits_s1[g*GRP +: GRP];
			grp_idx_d[g] = '0;
			for (int j = GRP - 1; j >= 0; j--) begin
				if (hits_s1[g*GRP + j]) begin
					grp_idx_d[g] = GRP_W'(j);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		grp_any_s2 <= grp_any_d;
		for (int g = 0; g < NGRP; g++) begin
			grp_idx_s2[g] <= grp_idx_d[g];
		end
	end

	// second level: lowest group with a hit
	always_comb begin
		any_d = |grp_any_s2;
		idx_d = '0;
		for (int g = NGRP - 1; g >= 0; g--) begin
			if (grp_any_s2[g]) begin
				idx_d = {NGRP_W'(g), grp_idx_s2[g]};
			end
		end
	end

	always_ff @(posedge clk) begin
		any_s3 <= any_d;
		idx_s3 <= idx_d;
	end

	assign hit_any = any_s3;
	assign hit_idx = idx_s3;

endmodule

/* design/ile_checker.sv */
// Port-level checks on the indexed list engine, bound to its top level.
module ile_checker
	import ile_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input value_t              value_out,
	input logic [WHERE_W-1:0]  where_found,
	input logic                found,
	input logic [STATUS_W-1:0] status,
	input logic [CNT_W-1:0]    count
);

	// hold a stalled response beat
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(value_out) && $stable(status)
			&& $stable(count) && $stable(found) && $stable(where_found))
		else $error("stalled response changed");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while one is in progress");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> count <= CNT_W'(DEPTH))
		else $error("count beyond depth");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_FULL |-> count == CNT_W'(DEPTH))
		else $error("full status with room left");

	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != ST_OK |-> value_out == '0 && !found && where_found == '0)
		else $error("error response carries data");

endmodule

bind indexed_list_engine_core ile_checker u_ile_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.value_out   (rsp.value_out),
	.where_found (rsp.where_found),
	.found       (rsp.found),
	.status      (rsp.status),
	.count       (rsp.count)
);
